// ----- sv/ftia_pkg.sv -----
`timescale 1ns / 1ps
// Types and constants of the flow table with idle aging.
// No dependencies.
package ftia_pkg;

   localparam logic [1:0] REQ_PACKET = 2'd0;
   localparam logic [1:0] REQ_STATS  = 2'd1;
   localparam logic [1:0] REQ_SWEEP  = 2'd2;

   localparam logic [2:0] KIND_VERDICT   = 3'd0;
   localparam logic [2:0] KIND_STATS_ACK = 3'd1;
   localparam logic [2:0] KIND_KEEPALIVE = 3'd2;
   localparam logic [2:0] KIND_EXPIRED   = 3'd3;
   localparam logic [2:0] KIND_DONE      = 3'd4;

   localparam logic [1:0] CSR_ENABLE    = 2'd0;
   localparam logic [1:0] CSR_TIMEOUT   = 2'd1;
   localparam logic [1:0] CSR_KEEPALIVE = 2'd2;
   localparam logic [1:0] CSR_GAME_PORT = 2'd3;

   localparam logic [7:0]  PROTO_TCP        = 8'd6;
   localparam logic [31:0] TIMEOUT_RESET    = 32'd30000;
   localparam logic [31:0] KEEPALIVE_RESET  = 32'd10000;
   localparam logic [15:0] GAME_PORT_RESET  = 16'd49152;
   localparam logic [31:0] PACKETS_MAX      = 32'hFFFF_FFFF;

   // per-entry payload held in the entry memory
   typedef struct packed {
      logic [31:0] dst_ip;
      logic [15:0] dst_port;
      logic [31:0] last_seen;
      logic [31:0] packets;
      logic [63:0] bytes;
   } entry_type;

   typedef struct packed {
      logic [2:0]  result_kind;
      logic        game_traffic;
      logic        entry_found;
      logic        table_full;
      logic [31:0] flow_src_ip;
      logic [15:0] flow_src_port;
      logic [31:0] flow_dst_ip;
      logic [15:0] flow_dst_port;
      logic [5:0]  active_flows;
      logic [63:0] grand_total_bytes;
      logic        last_of_run;
   } rsp_type;

endpackage

// ----- sv/ftia_req_if.sv -----
`timescale 1ns / 1ps
// Request channel: valid/ready with one request item.
// No dependencies.
interface ftia_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  req_type;
   logic [31:0] now_ms;
   logic [7:0]  protocol;
   logic [31:0] src_ip;
   logic [15:0] src_port;
   logic [31:0] dst_ip;
   logic [15:0] dst_port;
   logic [31:0] byte_count;

   modport source (output valid, req_type, now_ms, protocol, src_ip, src_port, dst_ip,
                   dst_port, byte_count, input ready);
   modport sink (input valid, req_type, now_ms, protocol, src_ip, src_port, dst_ip,
                 dst_port, byte_count, output ready);
endinterface

// ----- sv/ftia_rsp_if.sv -----
`timescale 1ns / 1ps
// Result channel: valid/ready with one result item.
// No dependencies.
interface ftia_rsp_if;
   logic        valid;
   logic        ready;
   logic [2:0]  result_kind;
   logic        game_traffic;
   logic        entry_found;
   logic        table_full;
   logic [31:0] flow_src_ip;
   logic [15:0] flow_src_port;
   logic [31:0] flow_dst_ip;
   logic [15:0] flow_dst_port;
   logic [5:0]  active_flows;
   logic [63:0] grand_total_bytes;
   logic        last_of_run;

   modport source (output valid, result_kind, game_traffic, entry_found, table_full,
                   flow_src_ip, flow_src_port, flow_dst_ip, flow_dst_port, active_flows,
                   grand_total_bytes, last_of_run, input ready);
   modport sink (input valid, result_kind, game_traffic, entry_found, table_full,
                 flow_src_ip, flow_src_port, flow_dst_ip, flow_dst_port, active_flows,
                 grand_total_bytes, last_of_run, output ready);
endinterface

// ----- sv/flow_table_with_idle_aging.sv -----
`timescale 1ns / 1ps
// Flow table with idle aging: top level.
// Depends on ftia_pkg, ftia_req_if and ftia_rsp_if.
//
// Flow table of TABLE_ENTRIES entries keyed by source address and port. Keys and
// valid bits sit in flops and are matched in parallel on the request transfer;
// destination, last-seen time, packet and byte counts sit in a synchronous memory
// with a registered read. Packet and stats requests: lookup plus memory read, then
// modify/write-back and result, held while the result register is full. A sweep
// makes a counting pass over the memory (read and evaluate each entry) that
// settles the flow count reported on every sweep result, then a reporting pass
// (read and evaluate each entry, plus output stalls) and the done result.
// One request is in flight at a time; the result register lets a finished
// result wait while the next request is taken. Request type 3 gives no result.
module flow_table_with_idle_aging
   import ftia_pkg::*;
#(
   parameter int TABLE_ENTRIES = 32
) (
   input  logic        clock,
   input  logic        reset,
   ftia_req_if.sink    req,
   ftia_rsp_if.source  rsp,
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [31:0] csr_wdata
);

   localparam int IW = $clog2(TABLE_ENTRIES);
   localparam int CW = $clog2(TABLE_ENTRIES + 1);
   localparam logic [IW-1:0] LAST_IDX = IW'(TABLE_ENTRIES - 1);

   typedef enum logic [2:0] {
      ST_IDLE, ST_LOOKUP, ST_S1_RD, ST_S1_EV, ST_S2_RD, ST_S2_EV, ST_DONE
   } state_type;

   state_type state_ff;

   // config registers
   logic        en_ff;
   logic [31:0] timeout_ff, keep_ff;
   logic [15:0] floor_ff;

   // key store, matched in parallel
   logic [TABLE_ENTRIES-1:0] valid_ff;
   logic [31:0] key_ip_ff   [TABLE_ENTRIES];
   logic [15:0] key_port_ff [TABLE_ENTRIES];
   logic [CW-1:0] cnt_ff, exp_cnt_ff;
   logic [63:0] total_ff;

   // latched request
   logic [1:0]  it_type_ff;
   logic [31:0] it_now_ff, it_sip_ff, it_dip_ff, it_bytes_ff;
   logic [15:0] it_sport_ff, it_dport_ff;
   logic        it_track_ff, it_game_ff, hit_ff, free_ok_ff;
   logic [IW-1:0] hit_idx_ff, free_idx_ff, idx_ff;

   // entry memory
   entry_type mem [TABLE_ENTRIES];
   entry_type rd_q;
   logic      rd_en, wr_en;
   logic [IW-1:0] rd_addr, wr_addr;
   entry_type wr_data;

   rsp_type rsp_ff;
   logic    rsp_valid_ff;
   logic    out_free;
   logic    rsp_load;

   // parallel key match and lowest free slot
   logic hit, free_ok;
   logic [IW-1:0] hit_idx, free_idx;

   always_comb begin
      hit = 1'b0;
      hit_idx = '0;
      free_ok = 1'b0;
      free_idx = '0;
      for (int i = TABLE_ENTRIES - 1; i >= 0; i--) begin
         if (valid_ff[i] && key_ip_ff[i] == req.src_ip && key_port_ff[i] == req.src_port) begin
            hit = 1'b1;
            hit_idx = IW'(i);
         end
         if (!valid_ff[i]) begin
            free_ok = 1'b1;
            free_idx = IW'(i);
         end
      end
   end

   assign out_free  = !rsp_valid_ff || rsp.ready;
   assign req.ready = (state_ff == ST_IDLE);

   logic accept;
   assign accept = req.valid && req.ready;

   // read-modify-write of one entry
   logic        pkt_upd, pkt_new, st_upd, do_insert;
   entry_type   upd;
   logic [31:0] idle;
   logic        expire, keepalive;

   always_comb begin
      pkt_upd   = (it_type_ff == REQ_PACKET) && it_track_ff && hit_ff;
      pkt_new   = (it_type_ff == REQ_PACKET) && it_track_ff && !hit_ff && free_ok_ff;
      st_upd    = (it_type_ff == REQ_STATS) && hit_ff;
      do_insert = pkt_new;
      upd = rd_q;
      upd.last_seen = it_now_ff;
      upd.bytes = rd_q.bytes + {32'd0, it_bytes_ff};
      if (pkt_upd && rd_q.packets != PACKETS_MAX) begin
         upd.packets = rd_q.packets + 32'd1;
      end
      if (pkt_new) begin
         upd.dst_ip = it_dip_ff;
         upd.dst_port = it_dport_ff;
         upd.packets = 32'd1;
         upd.bytes = {32'd0, it_bytes_ff};
      end
      idle      = it_now_ff - rd_q.last_seen;
      expire    = valid_ff[idx_ff] && (idle > timeout_ff);
      keepalive = valid_ff[idx_ff] && !expire && (idle > keep_ff) && en_ff;
   end

   // a result is loaded into the output register this cycle
   assign rsp_load = out_free && (state_ff == ST_LOOKUP || state_ff == ST_DONE ||
                                  (state_ff == ST_S2_EV && (expire || keepalive)));

   always_comb begin
      rd_en   = 1'b0;
      rd_addr = idx_ff;
      wr_en   = 1'b0;
      wr_addr = hit_ff ? hit_idx_ff : free_idx_ff;
      wr_data = upd;
      if (accept) begin
         rd_en = 1'b1;
         rd_addr = hit_idx;
      end else if (state_ff == ST_S1_RD || state_ff == ST_S2_RD) begin
         rd_en = 1'b1;
      end
      if (state_ff == ST_LOOKUP && out_free && (pkt_upd || pkt_new || st_upd)) begin
         wr_en = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_q <= mem[rd_addr];
      end
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // result fields of a lookup, a sweep entry and the done result
   rsp_type lk_rsp, sw_rsp, done_rsp;

   always_comb begin
      lk_rsp = '0;
      lk_rsp.flow_src_ip = it_sip_ff;
      lk_rsp.flow_src_port = it_sport_ff;
      lk_rsp.last_of_run = 1'b1;
      lk_rsp.active_flows = 6'(cnt_ff + (do_insert ? CW'(1) : CW'(0)));
      lk_rsp.grand_total_bytes = total_ff + (st_upd ? {32'd0, it_bytes_ff} : 64'd0);
      if (it_type_ff == REQ_PACKET) begin
         lk_rsp.result_kind = KIND_VERDICT;
         lk_rsp.game_traffic = it_track_ff && it_game_ff;
         lk_rsp.entry_found = pkt_upd;
         lk_rsp.table_full = it_track_ff && !hit_ff && !free_ok_ff;
         lk_rsp.flow_dst_ip = pkt_upd ? rd_q.dst_ip : it_dip_ff;
         lk_rsp.flow_dst_port = pkt_upd ? rd_q.dst_port : it_dport_ff;
      end else begin
         lk_rsp.result_kind = KIND_STATS_ACK;
         lk_rsp.entry_found = st_upd;
         lk_rsp.flow_dst_ip = st_upd ? rd_q.dst_ip : 32'd0;
         lk_rsp.flow_dst_port = st_upd ? rd_q.dst_port : 16'd0;
      end
      sw_rsp = '0;
      sw_rsp.result_kind = expire ? KIND_EXPIRED : KIND_KEEPALIVE;
      sw_rsp.entry_found = 1'b1;
      sw_rsp.flow_src_ip = key_ip_ff[idx_ff];
      sw_rsp.flow_src_port = key_port_ff[idx_ff];
      sw_rsp.flow_dst_ip = rd_q.dst_ip;
      sw_rsp.flow_dst_port = rd_q.dst_port;
      sw_rsp.active_flows = 6'(cnt_ff);
      sw_rsp.grand_total_bytes = total_ff;
      done_rsp = '0;
      done_rsp.result_kind = KIND_DONE;
      done_rsp.active_flows = 6'(cnt_ff);
      done_rsp.grand_total_bytes = total_ff;
      done_rsp.last_of_run = 1'b1;
   end

   // key store, no reset needed beyond valid bits
   always_ff @(posedge clock) begin
      if (state_ff == ST_LOOKUP && out_free && do_insert) begin
         key_ip_ff[free_idx_ff] <= it_sip_ff;
         key_port_ff[free_idx_ff] <= it_sport_ff;
      end
   end

   // request latch and result register
   always_ff @(posedge clock) begin
      if (accept) begin
         it_type_ff  <= req.req_type;
         it_now_ff   <= req.now_ms;
         it_sip_ff   <= req.src_ip;
         it_sport_ff <= req.src_port;
         it_dip_ff   <= req.dst_ip;
         it_dport_ff <= req.dst_port;
         it_bytes_ff <= req.byte_count;
         it_track_ff <= en_ff && (req.protocol == PROTO_TCP);
         it_game_ff  <= (req.dst_port >= floor_ff);
         hit_ff      <= hit;
         hit_idx_ff  <= hit_idx;
         free_ok_ff  <= free_ok;
         free_idx_ff <= free_idx;
      end
      if (state_ff == ST_LOOKUP || state_ff == ST_S2_EV || state_ff == ST_DONE) begin
         if (out_free) begin
            rsp_ff <= (state_ff == ST_LOOKUP) ? lk_rsp :
                      (state_ff == ST_DONE)   ? done_rsp : sw_rsp;
         end
      end else if (rsp.ready) begin
         rsp_ff <= rsp_ff;
      end
   end

   // control: state, config, counts, valid bits, result valid
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         en_ff        <= 1'b1;
         timeout_ff   <= TIMEOUT_RESET;
         keep_ff      <= KEEPALIVE_RESET;
         floor_ff     <= GAME_PORT_RESET;
         valid_ff     <= '0;
         cnt_ff       <= '0;
         exp_cnt_ff   <= '0;
         total_ff     <= '0;
         idx_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_we) begin
            case (csr_index)
               CSR_ENABLE:    en_ff <= csr_wdata[0];
               CSR_TIMEOUT:   timeout_ff <= csr_wdata;
               CSR_KEEPALIVE: keep_ff <= csr_wdata;
               CSR_GAME_PORT: floor_ff <= csr_wdata[15:0];
               default: ;
            endcase
         end
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp.ready) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            ST_IDLE: begin
               if (accept) begin
                  idx_ff <= '0;
                  exp_cnt_ff <= '0;
                  case (req.req_type)
                     REQ_PACKET, REQ_STATS: state_ff <= ST_LOOKUP;
                     REQ_SWEEP: state_ff <= ST_S1_RD;
                     default: state_ff <= ST_IDLE;
                  endcase
               end
            end
            ST_LOOKUP: begin
               if (out_free) begin
                  if (do_insert) begin
                     valid_ff[free_idx_ff] <= 1'b1;
                     cnt_ff <= cnt_ff + CW'(1);
                  end
                  if (st_upd) begin
                     total_ff <= total_ff + {32'd0, it_bytes_ff};
                  end
                  state_ff <= ST_IDLE;
               end
            end
            ST_S1_RD: state_ff <= ST_S1_EV;
            ST_S1_EV: begin
               if (idx_ff == LAST_IDX) begin
                  // flow count after the sweep, shown on all its results
                  cnt_ff <= cnt_ff - exp_cnt_ff - (expire ? CW'(1) : CW'(0));
                  idx_ff <= '0;
                  state_ff <= ST_S2_RD;
               end else begin
                  exp_cnt_ff <= exp_cnt_ff + (expire ? CW'(1) : CW'(0));
                  idx_ff <= idx_ff + IW'(1);
                  state_ff <= ST_S1_RD;
               end
            end
            ST_S2_RD: state_ff <= ST_S2_EV;
            ST_S2_EV: begin
               if (!(expire || keepalive) || out_free) begin
                  if (expire) begin
                     valid_ff[idx_ff] <= 1'b0;
                  end
                  if (idx_ff == LAST_IDX) begin
                     state_ff <= ST_DONE;
                  end else begin
                     idx_ff <= idx_ff + IW'(1);
                     state_ff <= ST_S2_RD;
                  end
               end
            end
            ST_DONE: begin
               if (out_free) begin
                  state_ff <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign rsp.valid             = rsp_valid_ff;
   assign rsp.result_kind       = rsp_ff.result_kind;
   assign rsp.game_traffic      = rsp_ff.game_traffic;
   assign rsp.entry_found       = rsp_ff.entry_found;
   assign rsp.table_full        = rsp_ff.table_full;
   assign rsp.flow_src_ip       = rsp_ff.flow_src_ip;
   assign rsp.flow_src_port     = rsp_ff.flow_src_port;
   assign rsp.flow_dst_ip       = rsp_ff.flow_dst_ip;
   assign rsp.flow_dst_port     = rsp_ff.flow_dst_port;
   assign rsp.active_flows      = rsp_ff.active_flows;
   assign rsp.grand_total_bytes = rsp_ff.grand_total_bytes;
   assign rsp.last_of_run       = rsp_ff.last_of_run;

endmodule
